/* hdl/swmf_pkg.sv */
// shared constants, types and cell link struct for the median filter
`timescale 1ns / 1ps
package swmf_pkg;

  localparam int MAX_HALF   = 7;
  localparam int MAX_LENGTH = 65536;
  localparam int DATA_WIDTH = 32;
  localparam int HALF_W     = 3;
  localparam int WIN_DEPTH  = 2 * MAX_HALF + 1;
  localparam int AGE_W      = $clog2(WIN_DEPTH + 1);
  localparam int CNT_W      = $clog2(MAX_LENGTH + 1);
  localparam int SUM_W      = DATA_WIDTH + CNT_W;
  localparam int RES_W      = $clog2(WIN_DEPTH + 1);
  localparam int STEP_W     = $clog2(SUM_W + 1);

  localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(3);

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef logic [CNT_W-1:0]             cnt_t;
  typedef logic [AGE_W-1:0]             age_t;

  // what one cell shows to its neighbors
  typedef struct packed {
    logic  valid;
    logic  lt;
    logic  dle;
    age_t  age;
    data_t val;
  } cell_link_t;

  // virtual neighbor below cell 0: always occupied and smaller than the sample
  localparam cell_link_t LINK_HEAD = '{valid: 1'b1, lt: 1'b1, dle: 1'b0, age: '0, val: '0};
  // virtual neighbor above the top cell: empty
  localparam cell_link_t LINK_TAIL = '{valid: 1'b0, lt: 1'b0, dle: 1'b0, age: '0, val: '0};

endpackage

/* hdl/swmf_in_if.sv */
// sample input channel: valid/ready with sample and last flag
`timescale 1ns / 1ps
interface swmf_in_if;
  logic                  valid;
  logic                  ready;
  swmf_pkg::data_t       sample;
  logic                  last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

/* hdl/swmf_out_if.sv */
// result output channel: valid/ready with median, mean and flags
`timescale 1ns / 1ps
interface swmf_out_if;
  logic                  valid;
  logic                  ready;
  swmf_pkg::data_t       median_value;
  logic                  is_last;
  swmf_pkg::data_t       mean_value;
  logic                  too_short;

  modport source (output valid, output median_value, output is_last,
                  output mean_value, output too_short, input ready);
  modport sink   (input valid, input median_value, input is_last,
                  input mean_value, input too_short, output ready);
endinterface

/* hdl/sliding_window_median_filter_top.sv */
// top level of the sliding window median filter: cell chain, sequencer, output register
`timescale 1ns / 1ps
// Running median over an odd window of 2*h+1 signed Q16.16 samples, h taken from
// cfg_data when a stream's first sample arrives (later writes apply to the next
// stream). The window lives in a chain of 15 sorted cells; a sample is inserted and
// the oldest entry dropped in the cycle the sample is accepted, so the median
// is simply the cell at rank h. A sample that yields no result leaves the input ready; one
// that yields k results (k = 1, or h+1 when the window first fills, plus h at stream end)
// holds the input off until all k are out; the result register loads one result per cycle
// while the output takes them. The closing result waits for the mean from a restoring
// divider of 49 steps. A stream shorter than the window ends in one result flagged
// too_short with zero values. The 65536th sample of a stream always closes it.
module sliding_window_median_filter_top (
  input  logic                          clk,
  input  logic                          rst_n,
  swmf_in_if.sink                       in_ch,
  swmf_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [swmf_pkg::HALF_W-1:0]   cfg_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EMIT  = 3'd1;
  localparam logic [2:0] ST_SHORT = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_FINAL = 3'd4;

  logic [2:0]                   state_r, state_nxt;
  logic [swmf_pkg::HALF_W-1:0]  window_half_r;
  logic [swmf_pkg::HALF_W-1:0]  h_r, h_nxt;
  swmf_pkg::cnt_t               count_r, count_nxt;
  logic                         end_r, end_nxt;
  logic [swmf_pkg::RES_W-1:0]   rem_r, rem_nxt;
  swmf_pkg::sum_t               sum_r, sum_nxt;

  logic                         out_valid_r, out_valid_nxt;
  swmf_pkg::data_t              out_med_r, out_med_nxt;
  logic                         out_last_r, out_last_nxt;
  swmf_pkg::data_t              out_mean_r, out_mean_nxt;
  logic                         out_short_r, out_short_nxt;

  logic                         in_acc;
  logic                         load_ok;
  logic                         load;
  logic [swmf_pkg::HALF_W-1:0]  h_cfg, h_cur;
  swmf_pkg::age_t               w_m1, w_cur;
  swmf_pkg::cnt_t               count_inc;
  logic                         end_in, full_now, first_full;
  logic [swmf_pkg::RES_W-1:0]   n_res;
  swmf_pkg::data_t              med;
  swmf_pkg::age_t               med_idx;

  logic                         cell_en, cell_clr;
  swmf_pkg::cell_link_t         link [swmf_pkg::WIN_DEPTH];
  logic [swmf_pkg::WIN_DEPTH-1:0] cell_valid;
  logic [swmf_pkg::WIN_DEPTH-1:0] del_vec;

  logic                         div_start, div_done;
  swmf_pkg::sum_t               div_dividend;
  swmf_pkg::data_t              div_quot;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_half_r <= swmf_pkg::HALF_RESET;
    end else if (cfg_we) begin
      window_half_r <= cfg_data;
    end
  end

  // window geometry for the sample on the input
  always_comb begin
    h_cfg = (window_half_r > swmf_pkg::HALF_W'(swmf_pkg::MAX_HALF)) ?
            swmf_pkg::HALF_W'(swmf_pkg::MAX_HALF) : window_half_r;
    h_cur      = (count_r == '0) ? h_cfg : h_r;
    w_m1       = swmf_pkg::AGE_W'(h_cur) << 1;
    w_cur      = w_m1 + swmf_pkg::AGE_W'(1);
    count_inc  = count_r + 1'b1;
    end_in     = in_ch.last || (count_inc == swmf_pkg::CNT_W'(swmf_pkg::MAX_LENGTH));
    full_now   = count_inc >= swmf_pkg::CNT_W'(w_cur);
    first_full = count_inc == swmf_pkg::CNT_W'(w_cur);
    n_res      = swmf_pkg::RES_W'(1)
               + (first_full ? swmf_pkg::RES_W'(h_cur) : '0)
               + (end_in ? swmf_pkg::RES_W'(h_cur) : '0);
  end

  // sorted cell chain
  for (genvar gi = 0; gi < swmf_pkg::WIN_DEPTH; gi++) begin : g_cell
    swmf_pkg::cell_link_t left_l, right_l;
    logic                 in_win;

    if (gi == 0) begin : g_head
      assign left_l = swmf_pkg::LINK_HEAD;
    end else begin : g_left
      assign left_l = link[gi-1];
    end
    if (gi == swmf_pkg::WIN_DEPTH - 1) begin : g_tail
      assign right_l = swmf_pkg::LINK_TAIL;
    end else begin : g_right
      assign right_l = link[gi+1];
    end

    assign in_win = swmf_pkg::AGE_W'(gi) <= w_m1;

    swmf_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (cell_en),
      .clr     (cell_clr),
      .in_win  (in_win),
      .x       (in_ch.sample),
      .w_m1    (w_m1),
      .left_i  (left_l),
      .right_i (right_l),
      .link_o  (link[gi])
    );

    assign cell_valid[gi] = link[gi].valid;
    assign del_vec[gi]    = link[gi].dle && !left_l.dle;
  end

  // median sits at rank h of the sorted chain
  assign med_idx = swmf_pkg::AGE_W'(h_r);
  assign med     = link[med_idx].val;

  swmf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign div_dividend = sum_r + swmf_pkg::SUM_W'(med);

  // handshakes
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign load_ok     = !out_valid_r || out_ch.ready;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    h_nxt         = h_r;
    count_nxt     = count_r;
    end_nxt       = end_r;
    rem_nxt       = rem_r;
    sum_nxt       = sum_r;
    cell_en       = 1'b0;
    cell_clr      = 1'b0;
    div_start     = 1'b0;
    load          = 1'b0;
    out_med_nxt   = out_med_r;
    out_last_nxt  = out_last_r;
    out_mean_nxt  = out_mean_r;
    out_short_nxt = out_short_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cell_en   = 1'b1;
          count_nxt = count_inc;
          h_nxt     = h_cur;
          end_nxt   = end_in;
          if (!full_now) begin
            if (end_in) begin
              state_nxt = ST_SHORT;
            end
          end else begin
            rem_nxt   = n_res;
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (rem_r == swmf_pkg::RES_W'(1) && end_r) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end else if (load_ok) begin
          load          = 1'b1;
          out_med_nxt   = med;
          out_last_nxt  = 1'b0;
          out_mean_nxt  = '0;
          out_short_nxt = 1'b0;
          sum_nxt       = sum_r + swmf_pkg::SUM_W'(med);
          rem_nxt       = rem_r - 1'b1;
          if (rem_r == swmf_pkg::RES_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (load_ok) begin
          load          = 1'b1;
          out_med_nxt   = med;
          out_last_nxt  = 1'b1;
          out_mean_nxt  = div_quot;
          out_short_nxt = 1'b0;
          count_nxt     = '0;
          sum_nxt       = '0;
          cell_clr      = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_SHORT: begin
        if (load_ok) begin
          load          = 1'b1;
          out_med_nxt   = '0;
          out_last_nxt  = 1'b1;
          out_mean_nxt  = '0;
          out_short_nxt = 1'b1;
          count_nxt     = '0;
          sum_nxt       = '0;
          cell_clr      = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // result register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      sum_r       <= '0;
      h_r         <= swmf_pkg::HALF_RESET;
      end_r       <= 1'b0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      h_r         <= h_nxt;
      end_r       <= end_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_med_r   <= out_med_nxt;
    out_last_r  <= out_last_nxt;
    out_mean_r  <= out_mean_nxt;
    out_short_r <= out_short_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.median_value = out_med_r;
  assign out_ch.is_last      = out_last_r;
  assign out_ch.mean_value   = out_mean_r;
  assign out_ch.too_short    = out_short_r;

`ifndef NO_ASSERTIONS
  // exactly one cell gives up its entry on every insertion
  a_del_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> $onehot(del_vec))
    else $error("cell chain removal is not one-hot");

  // occupied cells always form a run from the bottom of the chain
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_valid + swmf_pkg::WIN_DEPTH'(1)) & cell_valid) == '0)
    else $error("occupied cells are not contiguous");

  // divider starts only from the emit state with a nonzero count
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (state_r == ST_EMIT) && (count_r != '0))
    else $error("divider started out of sequence");

  // closing transfer leaves the stream state empty
  a_stream_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FINAL || state_r == ST_SHORT) && load) |=>
      (count_r == '0) && (sum_r == '0) && (cell_valid == '0))
    else $error("stream state not cleared after closing result");
`endif

endmodule

/* hdl/swmf_cell.sv */
// one cell of the sorted window chain: value, age and occupancy
`timescale 1ns / 1ps
module swmf_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 clr,
  input  logic                 in_win,
  input  swmf_pkg::data_t      x,
  input  swmf_pkg::age_t       w_m1,
  input  swmf_pkg::cell_link_t left_i,
  input  swmf_pkg::cell_link_t right_i,
  output swmf_pkg::cell_link_t link_o
);

  swmf_pkg::data_t val_r, val_nxt;
  swmf_pkg::age_t  age_r, age_nxt;
  logic            valid_r, valid_nxt;
  logic            lt, del, dle;
  swmf_pkg::data_t c_val, p_val;
  swmf_pkg::age_t  c_age, p_age;
  logic            c_lt, p_lt;

  // own compare and removal flag, removal prefix runs up the chain
  assign lt  = valid_r && ($signed(val_r) < $signed(x));
  assign del = in_win && (valid_r ? (age_r == w_m1) : left_i.valid);
  assign dle = del || left_i.dle;

  assign link_o = '{valid: valid_r, lt: lt, dle: dle, age: age_r, val: val_r};

  // compacted list after removal: entry at this slot and at the slot below
  always_comb begin
    c_val = dle ? right_i.val : val_r;
    c_age = dle ? right_i.age : age_r;
    c_lt  = dle ? right_i.lt  : lt;
    p_val = left_i.dle ? val_r : left_i.val;
    p_age = left_i.dle ? age_r : left_i.age;
    p_lt  = left_i.dle ? lt    : left_i.lt;
  end

  // insert the new sample into the compacted list
  always_comb begin
    val_nxt   = val_r;
    age_nxt   = age_r;
    valid_nxt = valid_r;
    if (clr) begin
      valid_nxt = 1'b0;
    end else if (en) begin
      valid_nxt = in_win && left_i.valid;
      priority if (c_lt) begin
        val_nxt = c_val;
        age_nxt = c_age + swmf_pkg::AGE_W'(1);
      end else if (p_lt) begin
        val_nxt = x;
        age_nxt = '0;
      end else begin
        val_nxt = p_val;
        age_nxt = p_age + swmf_pkg::AGE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    age_r <= age_nxt;
  end

endmodule

/* hdl/swmf_div.sv */
// restoring divider, one quotient bit per cycle, truncates toward zero
`timescale 1ns / 1ps
module swmf_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  swmf_pkg::sum_t  dividend,
  input  swmf_pkg::cnt_t  divisor,
  output logic            done,
  output swmf_pkg::data_t quotient
);

  logic [swmf_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                        done_r, done_nxt;
  logic                        neg_r, neg_nxt;
  logic [swmf_pkg::SUM_W-1:0]  quo_r, quo_nxt;
  logic [swmf_pkg::CNT_W-1:0]  rem_r, rem_nxt;
  swmf_pkg::cnt_t              dvs_r, dvs_nxt;
  logic [swmf_pkg::CNT_W:0]    rem_sh;
  logic [swmf_pkg::CNT_W:0]    rem_sub;
  logic                        ge;
  logic [swmf_pkg::SUM_W-1:0]  q_signed;

  // shift in the next dividend bit and try the subtract
  assign rem_sh  = {rem_r, quo_r[swmf_pkg::SUM_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_comb begin
    step_nxt = step_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      neg_nxt  = dividend[swmf_pkg::SUM_W-1];
      quo_nxt  = dividend[swmf_pkg::SUM_W-1] ? (~dividend + 1'b1) : dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      step_nxt = swmf_pkg::STEP_W'(swmf_pkg::SUM_W);
    end else if (step_r != '0) begin
      rem_nxt  = ge ? rem_sub[swmf_pkg::CNT_W-1:0] : rem_sh[swmf_pkg::CNT_W-1:0];
      quo_nxt  = {quo_r[swmf_pkg::SUM_W-2:0], ge};
      step_nxt = step_r - 1'b1;
      done_nxt = (step_r == swmf_pkg::STEP_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  // restore the sign of the magnitude quotient
  assign q_signed = neg_r ? (~quo_r + 1'b1) : quo_r;
  assign quotient = q_signed[swmf_pkg::DATA_WIDTH-1:0];
  assign done     = done_r;

endmodule
